/* hdl/hlpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlpd_pkg
// Shared types and constants of the handle-list payload decoder.
// ----------------------------------------------------------------------------
package hlpd_pkg;

  localparam int unsigned MaxHandlesDef  = 64;
  localparam int unsigned HeaderBytes    = 16;
  localparam logic [31:0] MagicWord      = 32'h3148_4C42;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned CfgDataW       = 16;
  localparam logic [CfgIdxW-1:0] CfgVersion = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWide    = 1'b1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StLength   = 3'd1;
  localparam logic [2:0] StMagic    = 3'd2;
  localparam logic [2:0] StVersion  = 3'd3;
  localparam logic [2:0] StHdrLen   = 3'd4;
  localparam logic [2:0] StCount    = 3'd5;
  localparam logic [2:0] StReserved = 3'd6;
  localparam logic [2:0] StHandle   = 3'd7;

  // Command from front to back: a finished handle to check, a status to
  // emit, or both (handle first).
  typedef struct packed {
    logic        chk;
    logic [63:0] handle;
    logic        wide;
    logic        fin;
    logic [2:0]  status_pre;  // status if no handle fault
    logic        hdl_gate;    // status_pre may become handle fault
  } hlpd_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] handle;
    logic [2:0]  status;
    logic        run_end;
  } hlpd_res_t;

endpackage
`default_nettype wire

/* hdl/handle_list_payload_decoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handle_list_payload_decoder_unit
// Byte-serial decoder of a handle-list payload.
//
// Input queue side: push a beat (data byte, final flag) while full is low.
// Result queue side: while empty is low the oldest result is shown; pop it.
// A complete handle gives a tentative handle beat; the final byte gives a
// status beat (after the handle beat if that byte also completes a handle).
// Header and ordinary bytes are handled in the front end alone. A completed
// handle is checked in the back end by a scan of the stored handles, one
// stored entry at a time over one read port (read in S_RD, compared in
// S_CMP). A status beat alone passes through the command queue and the
// back end's S_IDLE and S_SOUT states.
// A two-entry command queue lets the front take bytes during a scan.
// When the receiver stalls, the back end holds its result and the command
// queue fills, then full rises. Reset clears all payload state and loads
// expected_version=1 and wide_handles=1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module handle_list_payload_decoder_unit #(
  parameter int unsigned MAX_HANDLES = hlpd_pkg::MaxHandlesDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_final_byte,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_result_kind,
  output logic [63:0]                        out_handle_value,
  output logic [2:0]                         out_status_code,
  output logic                               out_run_end,
  input  wire logic                          cfg_we,
  input  wire logic [hlpd_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [hlpd_pkg::CfgDataW-1:0] cfg_data
);
  import hlpd_pkg::*;

  logic [15:0] ver_r;
  logic        wide_r;
  hlpd_cmd_t   fcmd, qcmd;
  logic        fpush, qfull, qempty, qpop, rvalid;
  hlpd_res_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r  <= 16'd1;
      wide_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgVersion: ver_r  <= cfg_data;
        CfgWide:    wide_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hlpd_front #(.MAX_HANDLES(MAX_HANDLES)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data_byte, .in_final_byte,
    .exp_version(ver_r), .wide(wide_r),
    .cmd(fcmd), .cmd_push(fpush), .cmd_full(qfull)
  );

  hlpd_cmdq u_q (
    .clk, .rst_n, .push(fpush), .wdata(fcmd), .full(qfull),
    .pop(qpop), .rdata(qcmd), .empty(qempty)
  );

  hlpd_back #(.MAX_HANDLES(MAX_HANDLES)) u_back (
    .clk, .rst_n, .cmd(qcmd), .cmd_empty(qempty), .cmd_pop(qpop),
    .res, .res_valid(rvalid), .res_ready(out_pop)
  );

  assign out_empty        = !rvalid;
  assign out_result_kind  = res.kind;
  assign out_handle_value = res.handle;
  assign out_status_code  = res.status;
  assign out_run_end      = res.run_end;

endmodule
`default_nettype wire

/* hdl/hlpd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlpd_front
// Parse header beats, assemble handles, issue commands to the back end.
// ----------------------------------------------------------------------------
module hlpd_front #(
  parameter int unsigned MAX_HANDLES = hlpd_pkg::MaxHandlesDef,
  parameter int unsigned PW = $clog2(hlpd_pkg::HeaderBytes + 8*MAX_HANDLES + 9)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_final_byte,
  input  wire logic [15:0]       exp_version,
  input  wire logic              wide,
  output hlpd_pkg::hlpd_cmd_t    cmd,
  output logic                   cmd_push,
  input  wire logic              cmd_full
);
  import hlpd_pkg::*;

  localparam logic [PW-1:0] PosCap = PW'(HeaderBytes + 8*MAX_HANDLES + 8);

  logic [PW-1:0] pos_r;
  logic [63:0]   hdr_r;
  logic [31:0]   cnt_r;
  logic [63:0]   asm_r;
  logic [2:0]    herr_r;
  logic          rbad_r;
  logic          acc;
  logic [PW-1:0] off;
  logic [2:0]    slot;
  logic [63:0]   asm_nxt;
  logic [63:0]   hdr_full;
  logic [2:0]    hf;
  logic [2:0]    herr_nxt;
  logic          rbad_nxt;
  logic          idx_ok;
  logic [PW:0]   len;
  logic [34:0]   explen;
  logic [2:0]    st;

  assign in_full  = cmd_full;
  assign acc      = in_push && !in_full;
  assign off      = pos_r - PW'(HeaderBytes);
  assign slot     = off[2:0];
  assign hdr_full = hdr_r;

  always_comb begin
    asm_nxt = (slot == 3'd0) ? 64'd0 : asm_r;
    asm_nxt[slot*8 +: 8] = in_data_byte;
  end

  always_comb begin
    hf = StOk;
    if (hdr_full[31:0] != MagicWord) hf = StMagic;
    else if (hdr_full[47:32] != exp_version) hf = StVersion;
    else if (hdr_full[63:48] != 16'(HeaderBytes)) hf = StHdrLen;
    else if (cnt_r > 32'(MAX_HANDLES)) hf = StCount;
  end

  assign rbad_nxt = rbad_r ||
    (pos_r >= PW'(12) && pos_r < PW'(HeaderBytes) && in_data_byte != 8'd0);
  assign herr_nxt = (pos_r == PW'(HeaderBytes - 1)) ? hf : herr_r;
  assign idx_ok   = {3'd0, 32'(off >> 3)} < {3'd0, cnt_r};
  assign len      = {1'b0, pos_r} + (PW+1)'(1);
  assign explen   = 35'(HeaderBytes) + {cnt_r, 3'd0};

  always_comb begin
    if (len < (PW+1)'(HeaderBytes)) st = StLength;
    else if (herr_nxt != StOk) st = herr_nxt;
    else if (35'(len) != explen) st = StLength;
    else if (rbad_nxt) st = StReserved;
    else st = StOk;
  end

  always_comb begin
    cmd.chk        = pos_r >= PW'(HeaderBytes) && slot == 3'd7 && idx_ok &&
                     herr_r == StOk && !rbad_r;
    cmd.handle     = asm_nxt;
    cmd.wide       = wide;
    cmd.fin        = in_final_byte;
    cmd.status_pre = st;
    cmd.hdl_gate   = st == StOk;
    cmd_push       = acc && (cmd.chk || in_final_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_final_byte)) begin
      pos_r  <= '0;
      hdr_r  <= '0;
      cnt_r  <= '0;
      herr_r <= StOk;
      rbad_r <= 1'b0;
    end else if (acc) begin
      if (pos_r < PW'(8)) hdr_r[pos_r[2:0]*8 +: 8] <= in_data_byte;
      else if (pos_r < PW'(12)) cnt_r[pos_r[1:0]*8 +: 8] <= in_data_byte;
      rbad_r <= rbad_nxt;
      herr_r <= herr_nxt;
      if (pos_r < PosCap) pos_r <= pos_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pos_r >= PW'(HeaderBytes)) asm_r <= asm_nxt;
  end

endmodule
`default_nettype wire

/* hdl/hlpd_cmdq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlpd_cmdq
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module hlpd_cmdq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire hlpd_pkg::hlpd_cmd_t  wdata,
  output logic                      full,
  input  wire logic                 pop,
  output hlpd_pkg::hlpd_cmd_t       rdata,
  output logic                      empty
);
  import hlpd_pkg::*;

  hlpd_cmd_t  mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= !wp_r;
      if (pop && !empty) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

/* hdl/hlpd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlpd_back
// Check handles against the seen list one entry at a time, emit results.
// ----------------------------------------------------------------------------
module hlpd_back #(
  parameter int unsigned MAX_HANDLES = hlpd_pkg::MaxHandlesDef,
  parameter int unsigned AW = (MAX_HANDLES > 1) ? $clog2(MAX_HANDLES) : 1,
  parameter int unsigned CW = $clog2(MAX_HANDLES + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire hlpd_pkg::hlpd_cmd_t  cmd,
  input  wire logic                 cmd_empty,
  output logic                      cmd_pop,
  output hlpd_pkg::hlpd_res_t       res,
  output logic                      res_valid,
  input  wire logic                 res_ready
);
  import hlpd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_HOUT = 5'b01000,
    S_SOUT = 5'b10000
  } st_t;

  st_t         st_r;
  logic [63:0] mem_r [MAX_HANDLES];
  logic [63:0] rd_r;
  logic [CW-1:0] seen_r;
  logic [CW-1:0] scan_r;
  logic        err_r;
  logic        dup_r;
  logic        bad;

  assign bad      = cmd.handle == 64'd0 || cmd.handle == '1 ||
                    (!cmd.wide && cmd.handle[63:32] != 32'd0) ||
                    seen_r >= CW'(MAX_HANDLES);
  assign res_valid = st_r == S_HOUT || (st_r == S_SOUT && cmd.fin);
  assign cmd_pop  = (st_r == S_HOUT && res_ready && !cmd.fin) ||
                    (st_r == S_SOUT && (!cmd.fin || res_ready));

  always_comb begin
    res.kind    = st_r == S_SOUT;
    res.handle  = (st_r == S_SOUT) ? 64'd0 : cmd.handle;
    res.status  = (st_r == S_HOUT) ? StOk :
                  (cmd.hdl_gate && (err_r || (cmd.chk && dup_r))) ? StHandle :
                  cmd.status_pre;
    res.run_end = st_r == S_SOUT;
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RD) rd_r <= mem_r[scan_r[AW-1:0]];
    if (st_r == S_HOUT && res_ready) mem_r[seen_r[AW-1:0]] <= cmd.handle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      seen_r <= '0;
      scan_r <= '0;
      err_r  <= 1'b0;
      dup_r  <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            scan_r <= '0;
            dup_r  <= cmd.chk && bad;
            if (!cmd.chk || err_r) st_r <= S_SOUT;
            else if (bad || seen_r == '0) st_r <= bad ? S_SOUT : S_HOUT;
            else st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_CMP;
        S_CMP: begin
          if (rd_r == cmd.handle) begin
            dup_r <= 1'b1;
            st_r  <= S_SOUT;
          end else if (scan_r + CW'(1) == seen_r) begin
            st_r <= S_HOUT;
          end else begin
            scan_r <= scan_r + CW'(1);
            st_r   <= S_RD;
          end
        end
        S_HOUT: begin
          if (res_ready) begin
            seen_r <= seen_r + CW'(1);
            st_r   <= cmd.fin ? S_SOUT : S_IDLE;
          end
        end
        S_SOUT: begin
          if (!cmd.fin) begin
            // handle fault without final byte: latch it, emit nothing
            err_r <= 1'b1;
            st_r  <= S_IDLE;
          end else if (res_ready) begin
            seen_r <= '0;
            err_r  <= 1'b0;
            dup_r  <= 1'b0;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/hlpd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hlpd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hlpd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic        out_result_kind,
  input wire logic [63:0] out_handle_value,
  input wire logic [2:0]  out_status_code,
  input wire logic        out_run_end
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_handle_value))
    else $error("result changed while stalled");
  a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_run_end == out_result_kind)
    else $error("run_end disagrees with kind");
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_result_kind |-> out_handle_value == 64'd0)
    else $error("status beat carries a handle");
  a_handle_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_result_kind |-> out_status_code == 3'd0 &&
      out_handle_value != 64'd0)
    else $error("bad handle beat");
endmodule

bind handle_list_payload_decoder_unit hlpd_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_result_kind,
  .out_handle_value, .out_status_code, .out_run_end
);
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the handle-list payload decoder. Payloads are fed byte by byte.
// A scoreboard predicts each handle beat and status beat, and compares every
// popped result with the oldest one it expects. Version and wide mode are
// changed between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_top;
  import hlpd_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [63:0] handle;
    logic [2:0]  status;
    logic        run_end;
  } beat_t;

  int fail_count = 0;

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  class payload_scoreboard;
    logic [15:0] version_reg;
    logic        wide_reg;
    int unsigned pos;
    logic [63:0] hdr;
    logic [31:0] count;
    logic [63:0] word;
    logic [2:0]  fault;
    bit          rsv_bad;
    logic [63:0] seen[$];
    beat_t       pending[$];

    function void clear_run();
      pos = 0; hdr = '0; count = '0; word = '0; fault = StOk; rsv_bad = 0;
      seen.delete();
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      logic [63:0] h;
      int unsigned off;
      int unsigned len;
      logic [2:0] st;
      bit ok;
      if (pos < 8) hdr[8*pos +: 8] = b;
      else if (pos < 12) count[8*(pos-8) +: 8] = b;
      else if (pos < HeaderBytes) begin
        if (b != 0) rsv_bad = 1;
        if (pos == HeaderBytes - 1) begin
          if (hdr[31:0] != MagicWord) fault = StMagic;
          else if (hdr[47:32] != version_reg) fault = StVersion;
          else if (hdr[63:48] != HeaderBytes) fault = StHdrLen;
          else if (count > MaxHandlesDef) fault = StCount;
        end
      end else begin
        off = pos - HeaderBytes;
        if (off % 8 == 0) word = '0;
        word[8*(off%8) +: 8] = b;
        if (off % 8 == 7 && off / 8 < count && fault == StOk && !rsv_bad) begin
          h = word;
          ok = !(h == 0 || &h || (!wide_reg && h[63:32] != 0));
          foreach (seen[i]) if (seen[i] == h) ok = 0;
          if (ok && seen.size() < MaxHandlesDef) begin
            seen.insert(seen.size(), h);
            pending.insert(pending.size(), beat_t'{1'b0, h, StOk, 1'b0});
          end else fault = StHandle;
        end
      end
      if (fin) begin
        len = pos + 1;
        if (len < HeaderBytes) st = StLength;
        else if (fault >= StMagic && fault <= StCount) st = fault;
        else if (64'(len) != 64'(HeaderBytes) + 64'(count) * 8) st = StLength;
        else if (rsv_bad) st = StReserved;
        else if (fault == StHandle) st = StHandle;
        else st = StOk;
        pending.insert(pending.size(), beat_t'{1'b1, 64'd0, st, 1'b1});
        clear_run();
      end else if (pos < HeaderBytes + 8 * MaxHandlesDef + 8) pos++;
    endfunction

    task check_beat(beat_t got);
      beat_t w;
      if (pending.size() == 0) begin
        report_mismatch("result beat with none expected");
        return;
      end
      w = pending.pop_front();
      if (got.kind !== w.kind) report_mismatch("result_kind");
      if (got.handle !== w.handle) report_mismatch("handle_value");
      if (got.status !== w.status) report_mismatch("status_code");
      if (got.run_end !== w.run_end) report_mismatch("run_end");
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_final_byte = 0;
  logic        out_empty;
  logic        out_pop = 0;
  logic        out_result_kind;
  logic [63:0] out_handle_value;
  logic [2:0]  out_status_code;
  logic        out_run_end;
  logic        cfg_we = 0;
  logic [CfgIdxW-1:0]  cfg_index = CfgVersion;
  logic [CfgDataW-1:0] cfg_data = '0;

  handle_list_payload_decoder_unit u_dut (.*);

  always #5 clk = ~clk;

  payload_scoreboard sb = new();
  bit sink_idle_on = 1;
  bit src_idle_on = 1;
  int hold_cycles = 0;
  bit done = 0;
  int items = 0;

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_beat('{out_result_kind, out_handle_value, out_status_code, out_run_end});
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_pop <= 0;
    end else out_pop <= !(sink_idle_on && $urandom_range(99) < 9);
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    while (src_idle_on && $urandom_range(99) < 9) begin
      in_push <= 0;
      @(negedge clk);
    end
    in_push <= 1; in_data_byte <= b; in_final_byte <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_byte(b, fin);
    items++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_push <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CfgVersion) sb.version_reg = val; else sb.wide_reg = val[0];
    @(negedge clk);
  endtask

  // mode: 0 good, 1 bad magic, 2 bad version, 3 bad header length,
  // 4 count too big, 5 reserved nonzero, 6 length short/long, 7 bad handle
  task automatic send_payload(int n, int mode);
    logic [7:0] bytes[$];
    logic [63:0] h;
    logic [63:0] hs[$];
    int extra;
    logic [31:0] cnt;
    cnt = (mode == 4) ? 32'($urandom_range(65, 300)) : 32'(n);
    for (int i = 0; i < 4; i++) bytes.insert(bytes.size(), MagicWord[8*i +: 8]);
    if (mode == 1) bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
    for (int i = 0; i < 2; i++)
      bytes.insert(bytes.size(), mode == 2 ? 8'($urandom) : sb.version_reg[8*i +: 8]);
    bytes.insert(bytes.size(), mode == 3 ? 8'($urandom_range(17, 255)) : 8'd16);
    bytes.insert(bytes.size(), 8'd0);
    for (int i = 0; i < 4; i++) bytes.insert(bytes.size(), cnt[8*i +: 8]);
    for (int i = 0; i < 4; i++) bytes.insert(bytes.size(), 8'd0);
    if (mode == 5) bytes[12 + $urandom_range(3)] = 8'($urandom_range(1, 255));
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: h = {32'd0, $urandom};
        1: h = {$urandom, $urandom};
        2: h = 64'd1 << $urandom_range(63);
        default: h = ~(64'd1 << $urandom_range(63));
      endcase
      if (h == 0) h = 1;
      if (mode == 7 && k == n - 1)
        case ($urandom_range(2))
          0: h = 0;
          1: h = '1;
          default: if (hs.size() > 0) h = hs[$urandom_range(hs.size() - 1)];
        endcase
      hs.insert(hs.size(), h);
      for (int i = 0; i < 8; i++) bytes.insert(bytes.size(), h[8*i +: 8]);
    end
    if (mode == 6) begin
      extra = $urandom_range(1, 12);
      if ($urandom_range(1)) repeat (extra) bytes.insert(bytes.size(), 8'($urandom));
      else repeat (extra) if (bytes.size() > 1) void'(bytes.pop_back());
    end
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic send_noise(int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    sb.version_reg = 16'd1; sb.wide_reg = 1; sb.clear_run();
    // directed
    send_payload(0, 0);
    for (int m = 1; m <= 7; m++) send_payload(1, m);
    send_noise(1);
    send_noise(8);
    drain();
    write_cfg(CfgVersion, 16'hffff);
    write_cfg(CfgWide, 16'd0);
    send_payload(1, 0);
    send_payload(2, 7);
    drain();
    write_cfg(CfgVersion, 16'd0);
    // back-pressure: long receiver hold while bytes keep coming
    hold_cycles = 400;
    send_payload(5, 0);
    drain();
    write_cfg(CfgWide, 16'd1);
    sink_idle_on = 0; src_idle_on = 0;
    send_payload(4, 0);
    sink_idle_on = 1; src_idle_on = 1;
    drain();
    // random phases
    for (int ph = 0; ph < 2; ph++) begin
      write_cfg(CfgVersion, 16'($urandom));
      write_cfg(CfgWide, 16'($urandom_range(1)));
      for (int k = 0; k < 2; k++) begin
        if ($urandom_range(9) == 0) send_noise($urandom_range(1, 20));
        else send_payload($urandom_range(0, 1), $urandom_range(9) < 5 ? 0
                          : $urandom_range(1, 7));
      end
      drain();
    end
    done = 1;
  end

  initial begin
    wait (done);
    if (fail_count == 0 && sb.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top failed");
    $finish;
  end
endmodule

/* sim.f */
hdl/hlpd_pkg.sv
hdl/hlpd_front.sv
hdl/hlpd_cmdq.sv
hdl/hlpd_back.sv
hdl/handle_list_payload_decoder_unit.sv
hdl/hlpd_checker.sv
dv/tb_top.sv
